// ===== design/voice_lfo_modulator_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef VOICE_LFO_MODULATOR_UNIT_DEFINES_SVH
`define VOICE_LFO_MODULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VLFO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VLFO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vlfo_pkg.sv =====
package vlfo_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned VolW     = 14;
  localparam int unsigned LfoW     = 16;

  localparam logic [VolW-1:0] VolMax = 14'h3FFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LFO_KIND    = 3'd0,
    REG_DELAY_TICKS = 3'd1,
    REG_RAMP_STEPS  = 3'd2,
    REG_MAX_DEPTH   = 3'd3,
    REG_DEPTH_STEP  = 3'd4,
    REG_PHASE_STEP  = 3'd5
  } vlfo_reg_e;

endpackage

// ===== design/voice_lfo_modulator_unit.sv =====
// Per-voice delayed, fading-in triangle LFO. Each accepted input word is one
// tick. While max_depth is nonzero the unit first counts delay_ticks ticks,
// then each tick ramps its depth in by depth_step for ramp_steps ticks (then
// holds max_depth), advances an 8-bit phase by phase_step and forms
// |depth| * triangle(phase), signed by the phase and scaled down by 1024
// (vibrato) or 256 (tremolo). In tremolo mode a change of the LFO value also
// yields left/right volumes (base plus LFO, clamped to 0..16383) with
// volume_update set; otherwise both volumes read 0. Setting restart on a word
// clears the running state before that tick. Throughput is one word per
// clock while the output is not stalled: the tick is evaluated combinationally
// (one 17x8 multiply followed by an add and clamp) and lands in an output
// register. The input is stalled only while a finished result waits downstream.
// Write the configuration registers only while the unit is idle.
module voice_lfo_modulator_unit
  import vlfo_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                restart_i,
  input  logic [VolW-1:0]     base_vol_left_i,
  input  logic [VolW-1:0]     base_vol_right_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [LfoW-1:0] lfo_value_o,
  output logic [VolW-1:0]     vol_left_o,
  output logic [VolW-1:0]     vol_right_o,
  output logic                volume_update_o
);

  // Configuration registers.
  logic        lfo_kind_q;
  logic [7:0]  delay_ticks_q;
  logic [7:0]  ramp_steps_q;
  logic [15:0] max_depth_q;
  logic [15:0] depth_step_q;
  logic [7:0]  phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_kind_q    <= 1'b0;
      delay_ticks_q <= '0;
      ramp_steps_q  <= '0;
      max_depth_q   <= '0;
      depth_step_q  <= '0;
      phase_step_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LFO_KIND:    lfo_kind_q    <= cfg_data_i[0];
        REG_DELAY_TICKS: delay_ticks_q <= cfg_data_i[7:0];
        REG_RAMP_STEPS:  ramp_steps_q  <= cfg_data_i[7:0];
        REG_MAX_DEPTH:   max_depth_q   <= cfg_data_i;
        REG_DEPTH_STEP:  depth_step_q  <= cfg_data_i;
        REG_PHASE_STEP:  phase_step_q  <= cfg_data_i[7:0];
        default: ;  // ignore writes beyond the register list
      endcase
    end
  end

  // Running LFO state.
  logic [7:0]  delay_count_q, delay_count_d;
  logic [7:0]  ramp_count_q,  ramp_count_d;
  logic [15:0] cur_depth_q,   cur_depth_d;
  logic [7:0]  phase_q,       phase_d;
  logic [15:0] lfo_out_q,     lfo_out_d;
  logic [15:0] last_sent_q,   last_sent_d;

  // Output register.
  logic            out_valid_q;
  logic [LfoW-1:0] lfo_value_q;
  logic [VolW-1:0] vol_left_q, vol_left_d;
  logic [VolW-1:0] vol_right_q, vol_right_d;
  logic            upd_q, upd_d;

  logic in_accept;

  // Stall the input only while a result is held and not taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Tick evaluation.
  logic [7:0]  s_delay, s_ramp, s_phase;
  logic [15:0] s_depth, s_lfo, s_last;
  logic        active, step_adv, send;
  logic [7:0]  ph_next, ph_abs;
  logic [8:0]  tri_w;
  logic [16:0] depth_abs;
  logic [24:0] mag;
  logic [15:0] q_scaled, lfo_adv;
  logic [15:0] depth_adv;
  logic [7:0]  ramp_adv;
  logic signed [17:0] sum_l, sum_r;

  function automatic logic [VolW-1:0] clamp_vol(input logic signed [17:0] v);
    logic [VolW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0, VolMax})) begin
      r = VolMax;
    end else begin
      r = v[VolW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    // Restart clears the state seen by this tick.
    s_delay = restart_i ? '0 : delay_count_q;
    s_ramp  = restart_i ? '0 : ramp_count_q;
    s_depth = restart_i ? '0 : cur_depth_q;
    s_phase = restart_i ? '0 : phase_q;
    s_lfo   = restart_i ? '0 : lfo_out_q;
    s_last  = restart_i ? '0 : last_sent_q;

    active   = (max_depth_q != '0);
    step_adv = active && (s_delay == delay_ticks_q);

    // Depth fade-in.
    if (s_ramp >= ramp_steps_q) begin
      depth_adv = max_depth_q;
      ramp_adv  = s_ramp;
    end else begin
      depth_adv = (s_ramp != '0) ? s_depth + depth_step_q : depth_step_q;
      ramp_adv  = s_ramp + 8'd1;
    end

    // Triangle of the new phase, scaled by |depth|.
    ph_next   = s_phase + phase_step_q;
    ph_abs    = ph_next[7] ? (8'd0 - ph_next) : ph_next;
    tri_w     = (ph_abs <= 8'd64) ? {ph_abs, 1'b0} : (9'd256 - {ph_abs, 1'b0});
    depth_abs = depth_adv[15] ? (17'd0 - {1'b1, depth_adv}) : {1'b0, depth_adv};
    mag       = depth_abs * {9'd0, tri_w[7:0]};
    q_scaled  = lfo_kind_q ? mag[23:8] : {1'b0, mag[24:10]};
    lfo_adv   = ph_next[7] ? (16'd0 - q_scaled) : q_scaled;

    // Delay countdown, or advance the wave.
    delay_count_d = s_delay;
    ramp_count_d  = s_ramp;
    cur_depth_d   = s_depth;
    phase_d       = s_phase;
    lfo_out_d     = s_lfo;
    if (active && !step_adv) begin
      delay_count_d = s_delay + 8'd1;
    end else if (step_adv) begin
      ramp_count_d = ramp_adv;
      cur_depth_d  = depth_adv;
      phase_d      = ph_next;
      lfo_out_d    = lfo_adv;
    end

    // Volume send in tremolo mode on a change of the LFO value.
    send        = active && lfo_kind_q && (s_last != lfo_out_d);
    last_sent_d = send ? lfo_out_d : s_last;

    sum_l = $signed({4'b0, base_vol_left_i})  + $signed({{2{lfo_out_d[15]}}, lfo_out_d});
    sum_r = $signed({4'b0, base_vol_right_i}) + $signed({{2{lfo_out_d[15]}}, lfo_out_d});
    vol_left_d  = send ? clamp_vol(sum_l) : '0;
    vol_right_d = send ? clamp_vol(sum_r) : '0;
    upd_d       = send;
  end

  // Advance the state on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_count_q <= '0;
      ramp_count_q  <= '0;
      cur_depth_q   <= '0;
      phase_q       <= '0;
      lfo_out_q     <= '0;
      last_sent_q   <= '0;
    end else if (in_accept) begin
      delay_count_q <= delay_count_d;
      ramp_count_q  <= ramp_count_d;
      cur_depth_q   <= cur_depth_d;
      phase_q       <= phase_d;
      lfo_out_q     <= lfo_out_d;
      last_sent_q   <= last_sent_d;
    end
  end

  // Hold the result until taken; load a new one on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lfo_value_q <= lfo_out_d;
      vol_left_q  <= vol_left_d;
      vol_right_q <= vol_right_d;
      upd_q       <= upd_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lfo_value_o     = $signed(lfo_value_q);
  assign vol_left_o      = vol_left_q;
  assign vol_right_o     = vol_right_q;
  assign volume_update_o = upd_q;

endmodule

// ===== design/vlfo_checker.sv =====
`include "voice_lfo_modulator_unit_defines.svh"

module vlfo_checker
  import vlfo_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [LfoW-1:0] lfo_value_o,
  input logic [VolW-1:0]        vol_left_o,
  input logic [VolW-1:0]        vol_right_o,
  input logic                   volume_update_o
);

  // A held result stays presented while stalled.
  `VLFO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(lfo_value_o) && $stable(volume_update_o), "result dropped or changed under stall")

  // The input stalls only behind a waiting result.
  `VLFO_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a waiting result")

  // Volumes are zero unless an update is flagged.
  `VLFO_ASSERT_IMP(a_vol_zero, clk_i, rst_ni, out_valid_o && !volume_update_o, vol_left_o == '0 && vol_right_o == '0, "volume nonzero without update")

  // An accepted word shows up as a result in the next cycle.
  `VLFO_ASSERT_NXT(a_accept_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o, "accepted word produced no result")

endmodule

bind voice_lfo_modulator_unit vlfo_checker u_vlfo_checker (.*);
